FILE: sv/tlvf_pkg.sv
// shared types and constants for the three-level volume fader
package tlvf_pkg;

    // widths of the volume and fade timer state
    localparam int VOL_W   = 8;
    localparam int TIMER_W = 11;
    localparam int DELTA_W = 12;

    // reset values of the full and reduced volumes
    localparam logic [VOL_W-1:0] FULL_RESET    = 8'd255;
    localparam logic [VOL_W-1:0] REDUCED_RESET = 8'd209;

    // floor(v*82/100) as (v * RED_MUL) >> RED_SHIFT, exact for 8-bit v
    localparam int               RED_MUL_W = 22;
    localparam int               RED_SHIFT = 22;
    localparam logic [RED_MUL_W-1:0] RED_MUL = 22'd3439408;

    // request commands
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_FADE_UP   = 3'd1,
        CMD_FADE_DOWN = 3'd2,
        CMD_FADE_OUT  = 3'd3,
        CMD_SET_MAX   = 3'd4
    } cmd_t;

    // fader target levels
    typedef enum logic [1:0] {
        LVL_OUT  = 2'd0,
        LVL_DOWN = 2'd1,
        LVL_UP   = 2'd2
    } level_t;

endpackage

FILE: sv/three_level_volume_fader_unit.sv
// three-level volume fader: fade commands, set max and linear ramp ticks
//
// One input request per command (cmd, delta_ticks, max_volume) on a
// valid/ready channel; one result (volume, level, ramping, volume_written)
// per request on a valid/ready output channel, in order.
// A result passes through the stage 1 and stage 2 registers after its
// request is accepted. Throughput is one request per cycle while the
// receiver does not stall: stage 1 updates the fader state and registers the
// ramp numerator start*w + end*(FADE_TIME-w); stage 2 divides it by
// FADE_TIME with a reciprocal multiply and holds the result.
// A set max request that follows a tick takes the new volume straight
// from the stage 1 divider, so no bubble is needed between requests.
// Reset: level out, timer zero, volume 0, full volume 255, reduced 209;
// both stages empty, in_ready high.
// When the receiver stalls, the result stays in the output register, stage
// 1 may still take one more request, and in_ready drops once both are full.
module three_level_volume_fader_unit #(
    parameter int FADE_TIME    = 1500,
    parameter int SET_MAX_RAMP = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     cmd,
    input  logic [tlvf_pkg::DELTA_W-1:0]   delta_ticks,
    input  logic [tlvf_pkg::VOL_W-1:0]     max_volume,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tlvf_pkg::VOL_W-1:0]     volume,
    output logic [1:0]                     level,
    output logic                           ramping,
    output logic                           volume_written
);

    localparam int VW = tlvf_pkg::VOL_W;
    localparam int TW = tlvf_pkg::TIMER_W;
    localparam int DW = tlvf_pkg::DELTA_W;

    // ramp numerator and exact reciprocal divide by FADE_TIME
    localparam int ACC_W  = VW + $clog2(FADE_TIME + 1);
    localparam int DIV_L  = $clog2(FADE_TIME);
    localparam int DIV_S  = ACC_W + DIV_L;
    localparam int M_W    = ACC_W + 1;
    localparam int PROD_W = ACC_W + M_W;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_S) + longint'(FADE_TIME) - 64'd1) / longint'(FADE_TIME);
    localparam int RED_PW = VW + tlvf_pkg::RED_MUL_W;
    localparam int TIMER_MAX = (FADE_TIME > SET_MAX_RAMP) ? FADE_TIME : SET_MAX_RAMP;

    localparam logic [TW-1:0] FADE_LOAD = TW'(FADE_TIME);
    localparam logic [TW-1:0] SMAX_LOAD = TW'(SET_MAX_RAMP);

    // fader state
    tlvf_pkg::level_t         lvl_reg, lvl_next;
    logic [TW-1:0]            timer_reg, timer_next;
    logic [VW-1:0]            start_reg, start_next;
    logic [VW-1:0]            end_reg, end_next;
    logic [VW-1:0]            full_reg, full_next;
    logic [VW-1:0]            red_reg, red_next;

    // stage 1: numerator and the volume seen before it
    logic                     v1_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic                     wr_reg, wr_next;
    logic [VW-1:0]            cur_reg;
    tlvf_pkg::level_t         lvl1_reg;
    logic                     ramp1_reg;

    // stage 2: result register
    logic                     v2_reg;
    logic [VW-1:0]            vol2_reg;
    tlvf_pkg::level_t         lvl2_reg;
    logic                     ramp2_reg;
    logic                     wr2_reg;

    logic                     accept;
    logic                     adv1;
    logic [PROD_W-1:0]        div_prod;
    logic [VW-1:0]            cur_now;
    logic [RED_PW-1:0]        red_prod;
    logic [VW-1:0]            red_calc;
    logic [TW-1:0]            tick_timer;
    logic [TW-1:0]            weight;
    logic [ACC_W-1:0]         tick_acc;

    function automatic logic [VW-1:0] nominal(
        input tlvf_pkg::level_t lv,
        input logic [VW-1:0]    full_v,
        input logic [VW-1:0]    red_v
    );
        logic [VW-1:0] res;
        unique case (lv)
            tlvf_pkg::LVL_UP:   res = full_v;
            tlvf_pkg::LVL_DOWN: res = red_v;
            default:            res = '0;
        endcase
        return res;
    endfunction

    // pipeline control
    assign adv1     = v1_reg && (!v2_reg || out_ready);
    assign in_ready = !v1_reg || adv1;
    assign accept   = in_valid && in_ready;

    // volume after the newest request: divider output when it was a tick that wrote the volume
    assign div_prod = PROD_W'(acc_reg) * PROD_W'(DIV_M);
    assign cur_now  = wr_reg ? VW'(div_prod >> DIV_S) : cur_reg;

    // reduced volume from the new full volume
    assign red_prod = RED_PW'(max_volume) * RED_PW'(tlvf_pkg::RED_MUL);
    assign red_calc = red_prod[tlvf_pkg::RED_SHIFT +: VW];

    // ramp tick: saturating timer, clamped weight, numerator
    always_comb
    begin
        if (delta_ticks >= DW'(timer_reg))
            tick_timer = '0;
        else
            tick_timer = timer_reg - TW'(delta_ticks);
        weight   = (tick_timer > FADE_LOAD) ? FADE_LOAD : tick_timer;
        tick_acc = ACC_W'(start_reg) * ACC_W'(weight)
                 + ACC_W'(end_reg) * ACC_W'(FADE_LOAD - weight);
    end

    // command decode and next state
    always_comb
    begin
        lvl_next   = lvl_reg;
        timer_next = timer_reg;
        start_next = start_reg;
        end_next   = end_reg;
        full_next  = full_reg;
        red_next   = red_reg;
        acc_next   = tick_acc;
        wr_next    = 1'b0;
        unique case (cmd)
            tlvf_pkg::CMD_TICK:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = tick_timer;
                    wr_next    = 1'b1;
                end
            end
            tlvf_pkg::CMD_FADE_UP:
            begin
                if (lvl_reg != tlvf_pkg::LVL_UP)
                begin
                    start_next = nominal(lvl_reg, full_reg, red_reg);
                    lvl_next   = tlvf_pkg::LVL_UP;
                    end_next   = full_reg;
                    timer_next = FADE_LOAD;
                end
            end
            tlvf_pkg::CMD_FADE_DOWN:
            begin
                if (lvl_reg != tlvf_pkg::LVL_DOWN)
                begin
                    start_next = nominal(lvl_reg, full_reg, red_reg);
                    lvl_next   = tlvf_pkg::LVL_DOWN;
                    end_next   = red_reg;
                    timer_next = FADE_LOAD;
                end
            end
            tlvf_pkg::CMD_FADE_OUT:
            begin
                if (lvl_reg != tlvf_pkg::LVL_OUT)
                begin
                    start_next = nominal(lvl_reg, full_reg, red_reg);
                    lvl_next   = tlvf_pkg::LVL_OUT;
                    end_next   = '0;
                    timer_next = FADE_LOAD;
                end
            end
            tlvf_pkg::CMD_SET_MAX:
            begin
                full_next  = max_volume;
                red_next   = red_calc;
                start_next = cur_now;
                end_next   = nominal(lvl_reg, max_volume, red_calc);
                timer_next = SMAX_LOAD;
            end
            default:
            begin
            end
        endcase
    end

    // fader state and stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg   <= tlvf_pkg::LVL_OUT;
            timer_reg <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            full_reg  <= tlvf_pkg::FULL_RESET;
            red_reg   <= tlvf_pkg::REDUCED_RESET;
            v1_reg    <= 1'b0;
            acc_reg   <= '0;
            wr_reg    <= 1'b0;
            cur_reg   <= '0;
            lvl1_reg  <= tlvf_pkg::LVL_OUT;
            ramp1_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lvl_reg   <= lvl_next;
                timer_reg <= timer_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                full_reg  <= full_next;
                red_reg   <= red_next;
                acc_reg   <= acc_next;
                wr_reg    <= wr_next;
                cur_reg   <= cur_now;
                lvl1_reg  <= lvl_next;
                ramp1_reg <= (timer_next != '0);
                v1_reg    <= 1'b1;
            end
            else if (adv1)
            begin
                v1_reg <= 1'b0;
            end
        end
    end

    // stage 2 result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            vol2_reg  <= '0;
            lvl2_reg  <= tlvf_pkg::LVL_OUT;
            ramp2_reg <= 1'b0;
            wr2_reg   <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v2_reg    <= 1'b1;
                vol2_reg  <= cur_now;
                lvl2_reg  <= lvl1_reg;
                ramp2_reg <= ramp1_reg;
                wr2_reg   <= wr_reg;
            end
            else if (out_ready)
            begin
                v2_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = v2_reg;
    assign volume         = vol2_reg;
    assign level          = lvl2_reg;
    assign ramping        = ramp2_reg;
    assign volume_written = wr2_reg;

    // an empty result register never blocks a new request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty result register");

    // timer never loads beyond the longest ramp
    a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(timer_reg) <= TIMER_MAX)
        else $error("fade timer above its longest load");

    // reduced volume never exceeds full volume
    a_reduced_le_full: assert property (@(posedge clk) disable iff (!rst_n)
        red_reg <= full_reg)
        else $error("reduced volume above full volume");

endmodule

FILE: test/tb_top.sv
// testbench for the three-level volume fader: stimulus, prediction and checks
module tb_top;

    localparam int VOL_W   = tlvf_pkg::VOL_W;
    localparam int TIMER_W = tlvf_pkg::TIMER_W;
    localparam int DELTA_W = tlvf_pkg::DELTA_W;

    localparam int FADE_TICKS    = 1500;
    localparam int SET_MAX_TICKS = 50;
    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 90;
    localparam int DRAIN_CYCLES  = 8;

    // command codes with no meaning for the block
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [DELTA_W-1:0] delta;
        logic [VOL_W-1:0]   vmax;
    } fader_request_t;

    typedef struct packed {
        logic [VOL_W-1:0] volume;
        logic [1:0]       level;
        logic             ramping;
        logic             written;
    } fader_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         cmd = tlvf_pkg::CMD_TICK;
    logic [DELTA_W-1:0] delta_ticks = '0;
    logic [VOL_W-1:0]   max_volume = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [VOL_W-1:0]   volume;
    logic [1:0]         level;
    logic               ramping;
    logic               volume_written;

    fader_request_t pending_requests[$];
    fader_result_t  expected_results[$];

    // predicted fader state
    tlvf_pkg::level_t   lvl_q = tlvf_pkg::LVL_OUT;
    logic [TIMER_W-1:0] ramp_timer = '0;
    logic [VOL_W-1:0]   ramp_from = '0;
    logic [VOL_W-1:0]   ramp_to = '0;
    logic [VOL_W-1:0]   vol_now = '0;
    logic [VOL_W-1:0]   vol_full = tlvf_pkg::FULL_RESET;
    logic [VOL_W-1:0]   vol_reduced = tlvf_pkg::REDUCED_RESET;

    int n_accepted = 0;
    int n_written = 0;
    int n_fades = 0;
    int n_set_max = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cycles = 0;

    three_level_volume_fader_unit #(
        .FADE_TIME    (FADE_TICKS),
        .SET_MAX_RAMP (SET_MAX_TICKS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .delta_ticks    (delta_ticks),
        .max_volume     (max_volume),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .volume         (volume),
        .level          (level),
        .ramping        (ramping),
        .volume_written (volume_written)
    );

    always #HALF_PERIOD clk = ~clk;

    // nominal volume of a level
    function automatic logic [VOL_W-1:0] nominal_volume(input tlvf_pkg::level_t lv);
        if (lv == tlvf_pkg::LVL_UP)
            return vol_full;
        if (lv == tlvf_pkg::LVL_DOWN)
            return vol_reduced;
        return '0;
    endfunction

    // fade to a new level, ignored when already there
    function automatic void start_fade_to(input tlvf_pkg::level_t target);
        if (lvl_q == target)
            return;
        ramp_from  = nominal_volume(lvl_q);
        lvl_q      = target;
        ramp_to    = nominal_volume(target);
        ramp_timer = TIMER_W'(FADE_TICKS);
        n_fades++;
    endfunction

    // update the predicted state for one request and queue its result
    function automatic void advance_fader(input logic [2:0] c,
                                          input logic [DELTA_W-1:0] d,
                                          input logic [VOL_W-1:0] m);
        fader_result_t r;
        int unsigned   w;
        int unsigned   acc;
        r.written = 1'b0;
        case (c)
            tlvf_pkg::CMD_TICK:
            begin
                if (ramp_timer != '0)
                begin
                    ramp_timer = (d >= ramp_timer) ? '0 : TIMER_W'(ramp_timer - d);
                    w = 32'(ramp_timer);
                    if (w > FADE_TICKS)
                        w = FADE_TICKS;
                    acc = ramp_from * w + ramp_to * (FADE_TICKS - w);
                    vol_now = VOL_W'(acc / FADE_TICKS);
                    r.written = 1'b1;
                    n_written++;
                end
            end
            tlvf_pkg::CMD_FADE_UP:   start_fade_to(tlvf_pkg::LVL_UP);
            tlvf_pkg::CMD_FADE_DOWN: start_fade_to(tlvf_pkg::LVL_DOWN);
            tlvf_pkg::CMD_FADE_OUT:  start_fade_to(tlvf_pkg::LVL_OUT);
            tlvf_pkg::CMD_SET_MAX:
            begin
                // reduced volume is 82 percent of full, rounded down
                vol_full    = m;
                vol_reduced = VOL_W'((int'(m) * 82) / 100);
                ramp_from   = vol_now;
                ramp_to     = nominal_volume(lvl_q);
                ramp_timer  = TIMER_W'(SET_MAX_TICKS);
                n_set_max++;
            end
            default: ;
        endcase
        r.volume  = vol_now;
        r.level   = lvl_q;
        r.ramping = (ramp_timer != '0);
        expected_results.push_back(r);
        n_accepted++;
    endfunction

    function automatic void push_request(input logic [2:0] c, input int d, input int m);
        fader_request_t q;
        q.cmd   = c;
        q.delta = DELTA_W'(d);
        q.vmax  = VOL_W'(m);
        pending_requests.push_back(q);
    endfunction

    function automatic int ramp_delta();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, 400);
    endfunction

    function automatic int any_volume();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [2:0] any_fade();
        case ($urandom_range(0, 2))
            0:       return tlvf_pkg::CMD_FADE_UP;
            1:       return tlvf_pkg::CMD_FADE_DOWN;
            default: return tlvf_pkg::CMD_FADE_OUT;
        endcase
    endfunction

    // mostly fade or set max requests followed by ramp ticks, plus noise
    function automatic void queue_random_requests(input int count);
        int made;
        int kind;
        int n_ticks;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                push_request(any_fade(), $urandom_range(0, 4095), $urandom_range(0, 255));
                n_ticks = $urandom_range(3, 12);
                for (int i = 0; i < n_ticks; i++)
                    push_request(tlvf_pkg::CMD_TICK, ramp_delta(), $urandom_range(0, 255));
                made += n_ticks + 1;
            end
            else if (kind < 65)
            begin
                push_request(tlvf_pkg::CMD_SET_MAX, $urandom_range(0, 4095), any_volume());
                n_ticks = $urandom_range(1, 8);
                for (int i = 0; i < n_ticks; i++)
                    push_request(tlvf_pkg::CMD_TICK, $urandom_range(0, 30),
                                 $urandom_range(0, 255));
                made += n_ticks + 1;
            end
            else if (kind < 90)
            begin
                push_request(tlvf_pkg::CMD_TICK, $urandom_range(0, 4095),
                             $urandom_range(0, 255));
                made++;
            end
            else
            begin
                // unused codes are ignored by the block and not counted
                push_request(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                             $urandom_range(0, 4095), $urandom_range(0, 255));
            end
        end
    endfunction

    // sender: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        fader_request_t req;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            cmd         <= tlvf_pkg::CMD_TICK;
            delta_ticks <= '0;
            max_volume  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_fader(cmd, delta_ticks, max_volume);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_requests.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    req = pending_requests.pop_front();
                    in_valid    <= 1'b1;
                    cmd         <= req.cmd;
                    delta_ticks <= req.delta;
                    max_volume  <= req.vmax;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // receiver: changing stall pattern, one long hold-off
    int  hold_left = 0;
    bit  held_once = 1'b0;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  beat = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (!held_once && n_accepted >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left--;
            beat++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (beat % 3 != 0);
                endcase
            end
        end
    end

    // result checker against the oldest predicted result
    always @(posedge clk)
    begin : monitor
        fader_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: volume %0d level %0d", volume, level);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (volume !== want.volume)
                begin
                    $error("volume: expected %0d, got %0d", want.volume, volume);
                    n_errors++;
                end
                if (level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, level);
                    n_errors++;
                end
                if (ramping !== want.ramping)
                begin
                    $error("ramping: expected %0d, got %0d", want.ramping, ramping);
                    n_errors++;
                end
                if (volume_written !== want.written)
                begin
                    $error("volume_written: expected %0d, got %0d", want.written,
                           volume_written);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // checked at the falling edge, once the rising edge updates have settled
    task automatic wait_all_done();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks, set max while out, fades, repeats and ignored codes
        push_request(tlvf_pkg::CMD_TICK, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 4095, 255);
        push_request(tlvf_pkg::CMD_SET_MAX, 4095, 255);
        push_request(tlvf_pkg::CMD_TICK, 4095, 0);
        push_request(tlvf_pkg::CMD_FADE_UP, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 1, 0);
        push_request(tlvf_pkg::CMD_FADE_UP, 4095, 255);
        push_request(tlvf_pkg::CMD_TICK, 700, 0);
        push_request(tlvf_pkg::CMD_FADE_DOWN, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 1499, 0);
        push_request(tlvf_pkg::CMD_TICK, 4095, 0);
        push_request(tlvf_pkg::CMD_TICK, 0, 0);
        push_request(tlvf_pkg::CMD_SET_MAX, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 25, 0);
        push_request(tlvf_pkg::CMD_SET_MAX, 0, 255);
        push_request(tlvf_pkg::CMD_FADE_OUT, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 2048, 0);
        push_request(CMD_SPARE_FIRST, 4095, 255);
        push_request(CMD_SPARE_FIRST + 3'd1, 4095, 255);
        push_request(CMD_SPARE_LAST, 4095, 255);
        push_request(tlvf_pkg::CMD_FADE_UP, 0, 0);
        push_request(tlvf_pkg::CMD_TICK, 750, 0);
        push_request(tlvf_pkg::CMD_SET_MAX, 0, 200);
        push_request(tlvf_pkg::CMD_TICK, 10, 0);
        push_request(tlvf_pkg::CMD_TICK, 4095, 0);
        wait_all_done();

        // random part, with a full drain of the sender in the middle
        queue_random_requests(800);
        wait_all_done();
        queue_random_requests(830);
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results from %0d requests: %0d fades, %0d set max",
                 n_checked, n_accepted, n_fades, n_set_max);
        $display("%0d ramp ticks recomputed the volume", n_written);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
